/* rtl/mfmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mfmc_pkg;

    // default sizes
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int CAP_BITS_DEF     = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_VERTEX_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_VERTEX = 2'd1;
    localparam logic [1:0] CFG_SINK_VERTEX   = 2'd2;

    // configuration reset values
    localparam logic [6:0] VERTEX_COUNT_RST  = 7'd64;
    localparam logic [5:0] SOURCE_VERTEX_RST = 6'd0;
    localparam logic [5:0] SINK_VERTEX_RST   = 6'd1;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_VERT  = 3'd1,
        ST_RANGE    = 3'd2,
        ST_SAME     = 3'd3,
        ST_ENDPOINT = 3'd4,
        ST_NEG_CAP  = 3'd5,
        ST_OVERFLOW = 3'd6
    } t_status;

endpackage

`default_nettype wire

/* rtl/max_flow_min_cut_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Max flow / min cut engine (Dinic).
// Input channel (i_valid / o_stall): one directed edge word per accept. Zero
// capacities are dropped; a stored edge goes through a head-of-list read,
// then forward arc and reverse arc writes, a dropped edge only through the
// accept. o_stall stays high while an edge is being stored or the graph is
// being solved. The word with i_last_edge set is handled first (stored unless
// dropped), then the solver runs: BFS level build, DFS with current-arc
// pointers, residual reachability, and a sweep over stored edges for the cut.
// Each arc/vertex memory is one-read one-write, so the time to the result is
// data dependent: it grows with arc visits and path arcs, repeated per BFS
// phase, plus the cut sweep over the stored edges.
// Output channel (o_valid / i_stall): exactly one result word per last
// edge, held in an output register until taken. The engine finishes and
// returns to accepting edges only when that register is free.
// Reset (synchronous, i_rst_n low) empties the edge store, clears the
// latched error and loads the configuration defaults. Config writes are
// taken in any cycle on i_cfg_we.
module max_flow_min_cut_engine
    import mfmc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF,
    parameter int CAP_BITS     = CAP_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    // edge channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [5:0]  i_edge_tail,
    input  wire logic [5:0]  i_edge_head,
    input  wire logic [31:0] i_capacity,
    input  wire logic        i_last_edge,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [47:0]      o_max_flow,
    output logic [47:0]      o_cut_capacity,
    output logic [63:0]      o_source_side_mask
);

    localparam int VB   = $clog2(MAX_VERTICES);
    localparam int DW   = $clog2(MAX_VERTICES + 1);
    localparam int LW   = DW;
    localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EB   = $clog2(MAX_EDGES + 1);
    localparam int AB   = EIW + 1;
    localparam int PW   = AB + 1;
    localparam int QW   = (VB > AB) ? VB : AB;
    localparam int ARCS = 2 * MAX_EDGES;
    localparam logic [PW-1:0] ARC_END = PW'(ARCS);

    typedef enum logic [4:0] {
        S_IDLE, S_LD1, S_LD2, S_START,
        S_BINIT, S_BPOP, S_BU, S_BU2, S_BARC, S_BCHK, S_BDONE,
        S_FTOP, S_FCUR, S_FSCAN, S_FS2, S_FS3, S_FSET, S_FPOP, S_FPOP2,
        S_AMS, S_AM1, S_AM2, S_AU0, S_AU1, S_AU2, S_AU3,
        S_C0, S_C1, S_C2, S_OUT
    } t_state;

    // memories
    logic [VB-1:0]       r_mem_tgt [ARCS];
    logic [CAP_BITS-1:0] r_mem_res [ARCS];
    logic [PW-1:0]       r_mem_nxt [ARCS];
    logic [CAP_BITS-1:0] r_mem_cap [MAX_EDGES];
    logic [PW-1:0]       r_mem_fst [MAX_VERTICES];
    logic [LW-1:0]       r_mem_lvl [MAX_VERTICES];
    logic [PW-1:0]       r_mem_cur [MAX_VERTICES];
    logic [QW-1:0]       r_mem_wlk [MAX_VERTICES];

    logic [VB-1:0]       rd_t;
    logic [CAP_BITS-1:0] rd_r;
    logic [PW-1:0]       rd_n;
    logic [CAP_BITS-1:0] rd_c;
    logic [PW-1:0]       rd_f;
    logic [LW-1:0]       rd_l;
    logic [PW-1:0]       rd_u;
    logic [QW-1:0]       rd_w;

    logic                tgt_we, res_we, nxt_we, cap_we, fst_we, lvl_we, cur_we, wlk_we;
    logic [AB-1:0]       tgt_wa, tgt_ra, res_wa, res_ra, nxt_wa, nxt_ra;
    logic [EIW-1:0]      cap_wa, cap_ra;
    logic [VB-1:0]       fst_wa, fst_ra, lvl_wa, lvl_ra, cur_wa, cur_ra, wlk_wa, wlk_ra;
    logic [VB-1:0]       tgt_wd;
    logic [CAP_BITS-1:0] res_wd, cap_wd;
    logic [PW-1:0]       nxt_wd, fst_wd, cur_wd;
    logic [LW-1:0]       lvl_wd;
    logic [QW-1:0]       wlk_wd;

    // control and payload registers
    t_state              r_state;
    logic [6:0]          r_vcount;
    logic [5:0]          r_src, r_snk;
    logic [VB-1:0]       r_tail, r_head;
    logic [CAP_BITS-1:0] r_cap;
    logic                r_last;
    logic [EB-1:0]       r_ecount, r_e;
    t_status             r_err, r_status;
    logic [MAX_VERTICES-1:0] r_visited, r_fv, r_cv, r_mask;
    logic [DW-1:0]       r_qh, r_qt, r_depth, r_i;
    logic [VB-1:0]       r_u, r_w, r_eh;
    logic [LW-1:0]       r_lu;
    logic [PW-1:0]       r_a, r_next;
    logic [CAP_BITS-1:0] r_res, r_b, r_ecap;
    logic [AB-1:0]       r_p;
    logic [47:0]         r_flow, r_cut;
    logic                r_o_valid;
    t_status             r_o_status;
    logic [47:0]         r_o_flow, r_o_cut;
    logic [MAX_VERTICES-1:0] r_o_mask;

    // combinational helpers
    logic [6:0]          w_n;
    logic [MAX_VERTICES-1:0] w_nmask;
    logic [47:0]         w_cap48;
    logic [CAP_BITS-1:0] w_raw;
    logic                w_acc, w_bad_ep, w_neg, w_store;
    logic [AB-1:0]       w_arc0, w_arc1;
    logic [PW-1:0]       w_ld_next1, w_ld_next2, w_cur_arc;
    logic                w_bfs_take, w_push, w_found, w_out_free;
    logic [DW-1:0]       w_dm1, w_ip1;
    logic [VB-1:0]       w_src, w_snk;

    assign w_n      = (r_vcount > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : r_vcount;
    assign w_cap48  = {16'b0, i_capacity};
    assign w_raw    = w_cap48[CAP_BITS-1:0];
    assign w_acc    = i_valid && (r_state == S_IDLE);
    assign w_bad_ep = ({1'b0, i_edge_tail} >= w_n) || ({1'b0, i_edge_head} >= w_n);
    assign w_neg    = w_raw[CAP_BITS-1];
    assign w_store  = (r_err == ST_OK) && !w_bad_ep && !w_neg && (w_raw != '0)
                      && (r_ecount < EB'(MAX_EDGES));
    assign w_arc0   = {r_ecount[EIW-1:0], 1'b0};
    assign w_arc1   = {r_ecount[EIW-1:0], 1'b1};
    assign w_ld_next1 = r_fv[r_tail] ? rd_f : ARC_END;
    assign w_ld_next2 = (r_head == r_tail) ? PW'(w_arc0) : (r_fv[r_head] ? rd_f : ARC_END);
    assign w_cur_arc  = r_cv[r_u] ? rd_u : (r_fv[r_u] ? rd_f : ARC_END);
    assign w_bfs_take = (rd_r != '0) && !r_visited[rd_t] && (r_qt < DW'(MAX_VERTICES));
    assign w_push     = (r_a != ARC_END) && (r_depth < DW'(MAX_VERTICES));
    assign w_found    = (r_res != '0) && r_visited[r_w] && (rd_l == LW'(r_lu + 1'b1));
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_dm1      = r_depth - DW'(1);
    assign w_ip1      = r_i + DW'(1);
    assign w_src      = r_src[VB-1:0];
    assign w_snk      = r_snk[VB-1:0];

    always_comb begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
            w_nmask[v] = (7'(v) < w_n);
        end
    end

    // memory port control per sequencer step
    always_comb begin
        tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0; tgt_ra = '0;
        res_we = 1'b0; res_wa = '0; res_wd = '0; res_ra = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;
        cap_we = 1'b0; cap_wa = '0; cap_wd = '0; cap_ra = '0;
        fst_we = 1'b0; fst_wa = '0; fst_wd = '0; fst_ra = '0;
        lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0; lvl_ra = '0;
        cur_we = 1'b0; cur_wa = '0; cur_wd = '0; cur_ra = '0;
        wlk_we = 1'b0; wlk_wa = '0; wlk_wd = '0; wlk_ra = '0;
        unique case (r_state)
            S_IDLE: begin
                fst_ra = i_edge_tail[VB-1:0];
            end
            S_LD1: begin
                tgt_we = 1'b1; tgt_wa = w_arc0; tgt_wd = r_head;
                res_we = 1'b1; res_wa = w_arc0; res_wd = r_cap;
                nxt_we = 1'b1; nxt_wa = w_arc0; nxt_wd = w_ld_next1;
                cap_we = 1'b1; cap_wa = r_ecount[EIW-1:0]; cap_wd = r_cap;
                fst_we = 1'b1; fst_wa = r_tail; fst_wd = PW'(w_arc0);
                fst_ra = r_head;
            end
            S_LD2: begin
                tgt_we = 1'b1; tgt_wa = w_arc1; tgt_wd = r_tail;
                res_we = 1'b1; res_wa = w_arc1; res_wd = '0;
                nxt_we = 1'b1; nxt_wa = w_arc1; nxt_wd = w_ld_next2;
                fst_we = 1'b1; fst_wa = r_head; fst_wd = PW'(w_arc1);
            end
            S_BINIT: begin
                lvl_we = 1'b1; lvl_wa = w_src; lvl_wd = '0;
                wlk_we = 1'b1; wlk_wa = '0; wlk_wd = QW'(w_src);
            end
            S_BPOP: begin
                wlk_ra = r_qh[VB-1:0];
            end
            S_BU: begin
                fst_ra = rd_w[VB-1:0];
                lvl_ra = rd_w[VB-1:0];
            end
            S_BARC, S_FSCAN: begin
                tgt_ra = r_a[AB-1:0];
                res_ra = r_a[AB-1:0];
                nxt_ra = r_a[AB-1:0];
            end
            S_BCHK: begin
                if (w_bfs_take) begin
                    lvl_we = 1'b1; lvl_wa = rd_t; lvl_wd = LW'(r_lu + 1'b1);
                    wlk_we = 1'b1; wlk_wa = r_qt[VB-1:0]; wlk_wd = QW'(rd_t);
                end
            end
            S_FTOP: begin
                cur_ra = r_u;
                fst_ra = r_u;
            end
            S_FS2: begin
                lvl_ra = rd_t;
            end
            S_FSET: begin
                cur_we = 1'b1; cur_wa = r_u; cur_wd = r_a;
                if (w_push) begin
                    wlk_we = 1'b1; wlk_wa = r_depth[VB-1:0]; wlk_wd = QW'(r_a[AB-1:0]);
                end else begin
                    wlk_ra = w_dm1[VB-1:0];
                end
            end
            S_FPOP: begin
                nxt_ra = rd_w[AB-1:0];
                tgt_ra = rd_w[AB-1:0] ^ AB'(1);
            end
            S_FPOP2: begin
                cur_we = 1'b1; cur_wa = rd_t; cur_wd = rd_n;
            end
            S_AMS, S_AU0: begin
                wlk_ra = r_i[VB-1:0];
            end
            S_AM1, S_AU1: begin
                res_ra = rd_w[AB-1:0];
            end
            S_AU2: begin
                res_we = 1'b1; res_wa = r_p; res_wd = rd_r - r_b;
                res_ra = r_p ^ AB'(1);
            end
            S_AU3: begin
                res_we = 1'b1; res_wa = r_p ^ AB'(1); res_wd = rd_r + r_b;
            end
            S_C0: begin
                tgt_ra = {r_e[EIW-1:0], 1'b0};
                cap_ra = r_e[EIW-1:0];
            end
            S_C1: begin
                tgt_ra = {r_e[EIW-1:0], 1'b1};
            end
            default: ;
        endcase
    end

    // memory arrays, registered read
    always_ff @(posedge i_clk) begin
        if (tgt_we) r_mem_tgt[tgt_wa] <= tgt_wd;
        rd_t <= r_mem_tgt[tgt_ra];
    end
    always_ff @(posedge i_clk) begin
        if (res_we) r_mem_res[res_wa] <= res_wd;
        rd_r <= r_mem_res[res_ra];
    end
    always_ff @(posedge i_clk) begin
        if (nxt_we) r_mem_nxt[nxt_wa] <= nxt_wd;
        rd_n <= r_mem_nxt[nxt_ra];
    end
    always_ff @(posedge i_clk) begin
        if (cap_we) r_mem_cap[cap_wa] <= cap_wd;
        rd_c <= r_mem_cap[cap_ra];
    end
    always_ff @(posedge i_clk) begin
        if (fst_we) r_mem_fst[fst_wa] <= fst_wd;
        rd_f <= r_mem_fst[fst_ra];
    end
    always_ff @(posedge i_clk) begin
        if (lvl_we) r_mem_lvl[lvl_wa] <= lvl_wd;
        rd_l <= r_mem_lvl[lvl_ra];
    end
    always_ff @(posedge i_clk) begin
        if (cur_we) r_mem_cur[cur_wa] <= cur_wd;
        rd_u <= r_mem_cur[cur_ra];
    end
    always_ff @(posedge i_clk) begin
        if (wlk_we) r_mem_wlk[wlk_wa] <= wlk_wd;
        rd_w <= r_mem_wlk[wlk_ra];
    end

    // sequencer, config registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= VERTEX_COUNT_RST;
            r_src     <= SOURCE_VERTEX_RST;
            r_snk     <= SINK_VERTEX_RST;
            r_ecount  <= '0;
            r_err     <= ST_OK;
            r_fv      <= '0;
            r_flow    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VERTEX_COUNT:  r_vcount <= i_cfg_data;
                    CFG_SOURCE_VERTEX: r_src    <= i_cfg_data[5:0];
                    CFG_SINK_VERTEX:   r_snk    <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            // result taken; a new word from S_OUT is loaded below instead
            if (r_o_valid && !i_stall && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                // edge load
                S_IDLE: begin
                    if (w_acc) begin
                        r_tail <= i_edge_tail[VB-1:0];
                        r_head <= i_edge_head[VB-1:0];
                        r_cap  <= w_raw;
                        r_last <= i_last_edge;
                        if (r_err == ST_OK) begin
                            if (w_bad_ep) begin
                                r_err <= ST_ENDPOINT;
                            end else if (w_neg) begin
                                r_err <= ST_NEG_CAP;
                            end else if (w_raw != '0 && r_ecount >= EB'(MAX_EDGES)) begin
                                r_err <= ST_OVERFLOW;
                            end
                        end
                        if (w_store) begin
                            r_state <= S_LD1;
                        end else if (i_last_edge) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_LD1: begin
                    r_fv[r_tail] <= 1'b1;
                    r_state      <= S_LD2;
                end
                S_LD2: begin
                    r_fv[r_head] <= 1'b1;
                    r_ecount     <= r_ecount + EB'(1);
                    r_state      <= r_last ? S_START : S_IDLE;
                end
                // config checks
                S_START: begin
                    r_flow <= '0;
                    r_cut  <= '0;
                    r_mask <= '0;
                    if (w_n == 7'd0) begin
                        r_status <= ST_NO_VERT;
                        r_state  <= S_OUT;
                    end else if ({1'b0, r_src} >= w_n || {1'b0, r_snk} >= w_n) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_OUT;
                    end else if (r_src == r_snk) begin
                        r_status <= ST_SAME;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= r_err;
                        r_state  <= (r_err == ST_OK) ? S_BINIT : S_OUT;
                    end
                end
                // BFS level build
                S_BINIT: begin
                    r_visited <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << w_src;
                    r_qh    <= '0;
                    r_qt    <= DW'(1);
                    r_state <= S_BPOP;
                end
                S_BPOP: begin
                    if (r_qh == r_qt) begin
                        r_state <= S_BDONE;
                    end else begin
                        r_qh    <= r_qh + DW'(1);
                        r_state <= S_BU;
                    end
                end
                S_BU: begin
                    r_u     <= rd_w[VB-1:0];
                    r_state <= S_BU2;
                end
                S_BU2: begin
                    r_lu    <= rd_l;
                    r_a     <= r_fv[r_u] ? rd_f : ARC_END;
                    r_state <= S_BARC;
                end
                S_BARC: begin
                    r_state <= (r_a == ARC_END) ? S_BPOP : S_BCHK;
                end
                S_BCHK: begin
                    if (w_bfs_take) begin
                        r_visited[rd_t] <= 1'b1;
                        r_qt            <= r_qt + DW'(1);
                    end
                    r_a     <= rd_n;
                    r_state <= S_BARC;
                end
                S_BDONE: begin
                    if (r_visited[w_snk]) begin
                        r_cv    <= '0;
                        r_depth <= '0;
                        r_u     <= w_src;
                        r_lu    <= '0;
                        r_state <= S_FTOP;
                    end else begin
                        r_mask  <= r_visited & w_nmask;
                        r_e     <= '0;
                        r_state <= S_C0;
                    end
                end
                // DFS over the level graph
                S_FTOP: begin
                    if (r_u == w_snk) begin
                        r_i     <= '0;
                        r_state <= S_AMS;
                    end else begin
                        r_state <= S_FCUR;
                    end
                end
                S_FCUR: begin
                    r_a     <= w_cur_arc;
                    r_state <= S_FSCAN;
                end
                S_FSCAN: begin
                    r_state <= (r_a == ARC_END) ? S_FSET : S_FS2;
                end
                S_FS2: begin
                    r_w     <= rd_t;
                    r_res   <= rd_r;
                    r_next  <= rd_n;
                    r_state <= S_FS3;
                end
                S_FS3: begin
                    if (w_found) begin
                        r_state <= S_FSET;
                    end else begin
                        r_a     <= r_next;
                        r_state <= S_FSCAN;
                    end
                end
                S_FSET: begin
                    r_cv[r_u] <= 1'b1;
                    if (w_push) begin
                        r_depth <= r_depth + DW'(1);
                        r_u     <= r_w;
                        r_lu    <= LW'(r_lu + 1'b1);
                        r_state <= S_FTOP;
                    end else if (r_depth == '0) begin
                        r_state <= S_BINIT;
                    end else begin
                        r_depth <= w_dm1;
                        r_state <= S_FPOP;
                    end
                end
                S_FPOP: begin
                    r_state <= S_FPOP2;
                end
                S_FPOP2: begin
                    r_u        <= rd_t;
                    r_lu       <= LW'(r_lu - 1'b1);
                    r_cv[rd_t] <= 1'b1;
                    r_state    <= S_FTOP;
                end
                // augment: bottleneck, then residual update
                S_AMS: begin
                    r_state <= S_AM1;
                end
                S_AM1: begin
                    r_state <= S_AM2;
                end
                S_AM2: begin
                    if (r_i == '0 || rd_r < r_b) begin
                        r_b <= rd_r;
                    end
                    if (w_ip1 < r_depth) begin
                        r_i     <= w_ip1;
                        r_state <= S_AMS;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_AU0;
                    end
                end
                S_AU0: begin
                    r_state <= S_AU1;
                end
                S_AU1: begin
                    r_p     <= rd_w[AB-1:0];
                    r_state <= S_AU2;
                end
                S_AU2: begin
                    r_state <= S_AU3;
                end
                S_AU3: begin
                    if (w_ip1 < r_depth) begin
                        r_i     <= w_ip1;
                        r_state <= S_AU0;
                    end else begin
                        r_flow  <= r_flow + 48'(r_b);
                        r_depth <= '0;
                        r_u     <= w_src;
                        r_lu    <= '0;
                        r_state <= S_FTOP;
                    end
                end
                // cut capacity sweep
                S_C0: begin
                    r_state <= (r_e == r_ecount) ? S_OUT : S_C1;
                end
                S_C1: begin
                    r_eh    <= rd_t;
                    r_ecap  <= rd_c;
                    r_state <= S_C2;
                end
                S_C2: begin
                    if (r_mask[rd_t] && !r_mask[r_eh]) begin
                        r_cut <= r_cut + 48'(r_ecap);
                    end
                    r_e     <= r_e + EB'(1);
                    r_state <= S_C0;
                end
                // result word, then start a new graph
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_flow   <= r_flow;
                        r_o_cut    <= r_cut;
                        r_o_mask   <= r_mask;
                        r_fv       <= '0;
                        r_ecount   <= '0;
                        r_err      <= ST_OK;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_status           = r_o_status;
    assign o_max_flow         = r_o_flow;
    assign o_cut_capacity     = r_o_cut;
    assign o_source_side_mask = 64'(r_o_mask);

    // checks
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD1) |-> (r_ecount < EB'(MAX_EDGES)))
        else $error("edge stored past store depth");

    a_path_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FTOP && r_u == w_snk) |-> (r_depth != '0))
        else $error("sink reached with empty path stack");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BPOP || r_state == S_BARC) |-> (r_qh <= r_qt))
        else $error("BFS queue head passed tail");

    a_graph_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_ecount == '0 && r_err == ST_OK && r_o_valid))
        else $error("graph not cleared after result");

endmodule

`default_nettype wire
